@@ rtl/sd_spi_command_engine_assert.svh @@
// Assertion macros for the SD SPI command engine
`ifndef SD_SPI_COMMAND_ENGINE_ASSERT_SVH
`define SD_SPI_COMMAND_ENGINE_ASSERT_SVH
// assert a property, clocked on clk_i, disabled in reset
`define SSCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert that a condition never holds, clocked on clk_i, disabled in reset
`define SSCE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

@@ rtl/sdspi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, constants and the command table of the SD SPI command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BlockBytes   = 512;
  localparam int unsigned CommandSlots = 28;
  localparam logic [4:0]  AppSlot      = 5'd23;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_XCHG  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    XF_NONE = 2'd0,
    XF_RD   = 2'd1,
    XF_WR   = 2'd2
  } xfer_e;

  typedef enum logic [1:0] {
    RS_R1  = 2'd0,
    RS_R1B = 2'd1,
    RS_R2  = 2'd2,
    RS_OCR = 2'd3
  } resp_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RESP_TO  = 3'd1,
    ST_BUSY_TO  = 3'd2,
    ST_WR_REJ   = 3'd3,
    ST_RD_TOKEN = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_LEAD_DESEL, PH_LEAD_SEL, PH_BUSY, PH_OPCODE, PH_ARG, PH_CRC,
    PH_R1, PH_R1B, PH_R2, PH_OCR, PH_WR_GAP, PH_WR_DATA, PH_WR_CRC,
    PH_WR_DRESP, PH_WR_GAP2, PH_WR_BUSYCHK, PH_RD_WAIT, PH_RD_DATA,
    PH_RD_CRC, PH_TAIL, PH_EXC1, PH_EXC2
  } phase_e;

  localparam logic [1:0] CfgBlockAddr   = 2'd0;
  localparam logic [1:0] CfgReadTimeout = 2'd1;
  localparam logic [1:0] CfgPollLimit   = 2'd2;

  typedef struct packed {
    logic [6:0] op;
    logic       needs_arg;
    logic [7:0] crc;
    xfer_e      xfer;
    resp_e      resp;
  } cmd_entry_t;

  // result of one step
  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_valid;
    logic       cs_active;
    logic       data_request;
    logic [7:0] rdata_byte;
    logic       rdata_valid;
    logic       done_res;
    logic [7:0] response_byte;
    logic [2:0] status;
  } result_t;

  function automatic cmd_entry_t cmd_lookup(input logic [4:0] slot);
    cmd_entry_t e;
    e = '{op: 7'd0, needs_arg: 1'b1, crc: 8'hFF, xfer: XF_NONE, resp: RS_R1};
    case (slot)
      5'd0:  begin e.op = 7'd0;  e.needs_arg = 1'b0; e.crc = 8'h95; end
      5'd1:  begin e.op = 7'd1;  e.needs_arg = 1'b0; end
      5'd2:  begin e.op = 7'd9;  e.needs_arg = 1'b0; e.xfer = XF_RD; end
      5'd3:  begin e.op = 7'd10; e.needs_arg = 1'b0; e.xfer = XF_RD; end
      5'd4:  begin e.op = 7'd12; e.needs_arg = 1'b0; end
      5'd5:  begin e.op = 7'd13; e.needs_arg = 1'b0; e.resp = RS_R2; end
      5'd6:  e.op = 7'd16;
      5'd7:  begin e.op = 7'd17; e.xfer = XF_RD; end
      5'd8:  begin e.op = 7'd18; e.xfer = XF_RD; end
      5'd9:  begin e.op = 7'd24; e.xfer = XF_WR; end
      5'd10: begin e.op = 7'd25; e.xfer = XF_WR; end
      5'd11: begin e.op = 7'd27; e.needs_arg = 1'b0; end
      5'd12: begin e.op = 7'd28; e.resp = RS_R1B; end
      5'd13: begin e.op = 7'd29; e.resp = RS_R1B; end
      5'd14: e.op = 7'd30;
      5'd15: e.op = 7'd32;
      5'd16: e.op = 7'd33;
      5'd17: e.op = 7'd34;
      5'd18: e.op = 7'd35;
      5'd19: e.op = 7'd36;
      5'd20: e.op = 7'd37;
      5'd21: begin e.op = 7'd38; e.resp = RS_R1B; end
      5'd22: begin e.op = 7'd42; e.resp = RS_R1B; end
      5'd23: begin e.op = 7'd55; e.needs_arg = 1'b0; end
      5'd24: e.op = 7'h40 | 7'd41;
      5'd25: begin e.op = 7'd58; e.needs_arg = 1'b0; e.resp = RS_OCR; end
      5'd26: e.op = 7'd59;
      5'd27: begin e.op = 7'd8; e.crc = 8'h87; e.resp = RS_OCR; end
      default: begin e.op = 7'd0; e.needs_arg = 1'b0; e.crc = 8'h95; end
    endcase
    return e;
  endfunction

endpackage

@@ rtl/sdspi_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_core
// Sequencer state and next-step logic; one item per enabled cycle.
// ----------------------------------------------------------------------------
module sdspi_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          kind_i,
  input  logic [4:0]          cmd_slot_i,
  input  logic [31:0]         cmd_argument_i,
  input  logic [7:0]          miso_byte_i,
  input  logic [7:0]          wdata_byte_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  output sdspi_pkg::result_t  res_o
);

  sdspi_pkg::phase_e phase_q, phase_d;
  logic [4:0]  slot_q, slot_d;
  logic        app_q, app_d, busy_q, busy_d, flush_q, flush_d, swap_q, swap_d;
  logic [15:0] blen_q, blen_d, sblen_q, sblen_d, bcnt_q, bcnt_d;
  logic [31:0] arg_q, arg_d;
  logic [8:0]  pcnt_q, pcnt_d, plim_q;
  logic [7:0]  tick_q, tick_d, mark_q, mark_d, last_q, last_d, rto_q;
  logic [2:0]  err_q, err_d;
  logic        baddr_q;

  sdspi_pkg::cmd_entry_t ent;
  sdspi_pkg::cmd_entry_t sent;
  logic [5:0]  op6;
  logic [8:0]  pinc, plim;
  logic        pexp;
  logic [15:0] binc;
  logic [7:0]  tdiff;
  logic [1:0]  kind;

  always_comb begin
    ent   = sdspi_pkg::cmd_lookup(app_q ? sdspi_pkg::AppSlot : slot_q);
    sent  = sdspi_pkg::cmd_lookup(cmd_slot_i);
    op6   = ent.op[5:0];
    pinc  = pcnt_q + 9'd1;
    plim  = (plim_q == 9'd0) ? 9'd1 : plim_q;
    pexp  = (pinc >= plim);
    binc  = bcnt_q + 16'd1;
    tdiff = tick_q - mark_q;
    kind  = kind_i;
  end

  always_comb begin
    phase_d = phase_q; slot_d = slot_q; app_d = app_q; busy_d = busy_q;
    flush_d = flush_q; swap_d = swap_q; blen_d = blen_q; sblen_d = sblen_q;
    bcnt_d = bcnt_q; arg_d = arg_q; pcnt_d = pcnt_q; tick_d = tick_q;
    mark_d = mark_q; last_d = last_q; err_d = err_q;
    res_o = '0;
    res_o.mosi_byte = 8'hFF;

    case (sdspi_pkg::kind_e'(kind))
      sdspi_pkg::KIND_TICK: tick_d = tick_q + 8'd1;
      sdspi_pkg::KIND_START: begin
        if (phase_q == sdspi_pkg::PH_IDLE) begin
          if (cmd_slot_i >= 5'(sdspi_pkg::CommandSlots)) begin
            res_o.done_res = 1'b1; res_o.response_byte = 8'hFF;
            res_o.status = sdspi_pkg::ST_RESP_TO;
          end else begin
            slot_d = cmd_slot_i; arg_d = cmd_argument_i; flush_d = 1'b0;
            app_d = sent.op[6];
            last_d = 8'hFF;
            phase_d = sdspi_pkg::PH_LEAD_DESEL; res_o.exchange_valid = 1'b1;
          end
        end
      end
      sdspi_pkg::KIND_FLUSH: begin
        if (phase_q == sdspi_pkg::PH_IDLE) begin
          if (busy_q) begin
            busy_d = 1'b0; flush_d = 1'b1;
            phase_d = sdspi_pkg::PH_LEAD_DESEL; res_o.exchange_valid = 1'b1;
          end else res_o.done_res = 1'b1;
        end
      end
      default: begin
        if (phase_q != sdspi_pkg::PH_IDLE) begin
          res_o.exchange_valid = 1'b1;
          res_o.cs_active = 1'b1;
          phase_d = phase_q;
          case (phase_q)
            sdspi_pkg::PH_LEAD_DESEL: phase_d = sdspi_pkg::PH_LEAD_SEL;
            sdspi_pkg::PH_LEAD_SEL, sdspi_pkg::PH_BUSY: begin
              if (phase_q == sdspi_pkg::PH_LEAD_SEL && (flush_q || busy_q)) begin
                busy_d = 1'b0; pcnt_d = '0; phase_d = sdspi_pkg::PH_BUSY;
              end else if (phase_q == sdspi_pkg::PH_BUSY && miso_byte_i == 8'h00) begin
                pcnt_d = pinc;
                if (pexp) begin err_d = sdspi_pkg::ST_BUSY_TO; phase_d = sdspi_pkg::PH_EXC1; end
              end else if (phase_q == sdspi_pkg::PH_BUSY && flush_q) begin
                phase_d = sdspi_pkg::PH_TAIL; res_o.cs_active = 1'b0;
              end else begin
                // enter opcode
                if (op6 == 6'd16) blen_d = arg_q[15:0];
                else if (op6 == 6'd9 || op6 == 6'd10) begin
                  sblen_d = blen_q; blen_d = 16'd16; swap_d = 1'b1;
                end else if ((op6 == 6'd17 || op6 == 6'd18 || op6 == 6'd24 ||
                              op6 == 6'd25) && !baddr_q)
                  arg_d = arg_q << $clog2(sdspi_pkg::BlockBytes);
                bcnt_d = '0;
                res_o.mosi_byte = {2'b01, op6};
                phase_d = sdspi_pkg::PH_OPCODE;
              end
            end
            sdspi_pkg::PH_OPCODE, sdspi_pkg::PH_ARG: begin
              if (phase_q == sdspi_pkg::PH_ARG && bcnt_q >= 16'd4) begin
                res_o.mosi_byte = ent.crc; phase_d = sdspi_pkg::PH_CRC;
              end else begin
                res_o.mosi_byte = 8'h00;
                if (ent.needs_arg) begin
                  res_o.mosi_byte = arg_q[31:24]; arg_d = {arg_q[23:0], 8'h00};
                end
                bcnt_d = binc; phase_d = sdspi_pkg::PH_ARG;
              end
            end
            sdspi_pkg::PH_CRC: begin pcnt_d = '0; phase_d = sdspi_pkg::PH_R1; end
            sdspi_pkg::PH_R1: begin
              if (miso_byte_i[7]) begin
                pcnt_d = pinc;
                if (pexp) begin
                  last_d = miso_byte_i; err_d = sdspi_pkg::ST_RESP_TO;
                  phase_d = sdspi_pkg::PH_EXC1;
                end
              end else begin
                last_d = miso_byte_i;
                case (ent.resp)
                  sdspi_pkg::RS_R1B: begin pcnt_d = '0; phase_d = sdspi_pkg::PH_R1B; end
                  sdspi_pkg::RS_R2:  phase_d = sdspi_pkg::PH_R2;
                  sdspi_pkg::RS_OCR: begin bcnt_d = '0; phase_d = sdspi_pkg::PH_OCR; end
                  default: phase_d = sdspi_pkg::PH_R2;
                endcase
                if (ent.resp == sdspi_pkg::RS_R1) phase_d = sdspi_pkg::PH_IDLE;
              end
            end
            sdspi_pkg::PH_R1B: begin
              if (miso_byte_i == 8'h00) begin
                pcnt_d = pinc;
                if (pexp) begin err_d = sdspi_pkg::ST_BUSY_TO; phase_d = sdspi_pkg::PH_EXC1; end
              end else phase_d = sdspi_pkg::PH_IDLE;
            end
            sdspi_pkg::PH_R2: phase_d = sdspi_pkg::PH_IDLE;
            sdspi_pkg::PH_OCR: begin
              res_o.rdata_byte = miso_byte_i; res_o.rdata_valid = 1'b1;
              bcnt_d = binc;
              if (binc >= 16'd4) phase_d = sdspi_pkg::PH_IDLE;
            end
            sdspi_pkg::PH_WR_GAP: begin
              bcnt_d = '0; res_o.mosi_byte = 8'hFE;
              res_o.data_request = (blen_q != 16'd0);
              phase_d = sdspi_pkg::PH_WR_DATA;
            end
            sdspi_pkg::PH_WR_DATA: begin
              if (bcnt_q < blen_q) begin
                bcnt_d = binc; res_o.mosi_byte = wdata_byte_i;
                res_o.data_request = (binc < blen_q);
              end else begin bcnt_d = '0; phase_d = sdspi_pkg::PH_WR_CRC; end
            end
            sdspi_pkg::PH_WR_CRC, sdspi_pkg::PH_RD_CRC: begin
              if (bcnt_q == 16'd0) bcnt_d = 16'd1;
              else if (phase_q == sdspi_pkg::PH_WR_CRC) phase_d = sdspi_pkg::PH_WR_DRESP;
              else begin phase_d = sdspi_pkg::PH_TAIL; res_o.cs_active = 1'b0; end
            end
            sdspi_pkg::PH_WR_DRESP: begin
              if (miso_byte_i[4:0] != 5'h05) begin
                err_d = sdspi_pkg::ST_WR_REJ; phase_d = sdspi_pkg::PH_EXC1;
              end else phase_d = sdspi_pkg::PH_WR_GAP2;
            end
            sdspi_pkg::PH_WR_GAP2: phase_d = sdspi_pkg::PH_WR_BUSYCHK;
            sdspi_pkg::PH_WR_BUSYCHK: begin
              if (miso_byte_i == 8'h00) busy_d = 1'b1;
              phase_d = sdspi_pkg::PH_TAIL; res_o.cs_active = 1'b0;
            end
            sdspi_pkg::PH_RD_WAIT: begin
              if (miso_byte_i == 8'hFE) begin
                bcnt_d = '0;
                phase_d = (blen_q != 16'd0) ? sdspi_pkg::PH_RD_DATA : sdspi_pkg::PH_RD_CRC;
              end else if (miso_byte_i != 8'hFF || tdiff >= rto_q) begin
                err_d = sdspi_pkg::ST_RD_TOKEN; phase_d = sdspi_pkg::PH_EXC1;
              end
            end
            sdspi_pkg::PH_RD_DATA: begin
              res_o.rdata_byte = miso_byte_i; res_o.rdata_valid = 1'b1;
              bcnt_d = binc;
              if (binc >= blen_q) begin bcnt_d = '0; phase_d = sdspi_pkg::PH_RD_CRC; end
            end
            sdspi_pkg::PH_EXC1: begin phase_d = sdspi_pkg::PH_EXC2; res_o.cs_active = 1'b0; end
            default: phase_d = sdspi_pkg::PH_IDLE;  // tail / exc2: finish below
          endcase

          // data phase entry (marked as PH_IDLE above from response steps)
          if (phase_d == sdspi_pkg::PH_IDLE &&
              phase_q != sdspi_pkg::PH_TAIL && phase_q != sdspi_pkg::PH_EXC2) begin
            case (ent.xfer)
              sdspi_pkg::XF_WR: phase_d = sdspi_pkg::PH_WR_GAP;
              sdspi_pkg::XF_RD: begin mark_d = tick_q; phase_d = sdspi_pkg::PH_RD_WAIT; end
              default: begin phase_d = sdspi_pkg::PH_TAIL; res_o.cs_active = 1'b0; end
            endcase
          end

          if (phase_q == sdspi_pkg::PH_TAIL || phase_q == sdspi_pkg::PH_EXC2) begin
            if (swap_q) begin blen_d = sblen_q; swap_d = 1'b0; end
            res_o.cs_active = 1'b0;
            if (!flush_q && app_q) begin
              app_d = 1'b0; last_d = 8'hFF; phase_d = sdspi_pkg::PH_LEAD_DESEL;
            end else begin
              phase_d = sdspi_pkg::PH_IDLE;
              res_o.exchange_valid = 1'b0;
              res_o.done_res = 1'b1;
              res_o.response_byte = flush_q ? 8'h00 : last_q;
              res_o.status = (phase_q == sdspi_pkg::PH_TAIL) ? sdspi_pkg::ST_OK : err_q;
              flush_d = 1'b0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::PH_IDLE; slot_q <= '0; app_q <= 1'b0; busy_q <= 1'b0;
      flush_q <= 1'b0; swap_q <= 1'b0; blen_q <= 16'd512; sblen_q <= 16'd512;
      bcnt_q <= '0; arg_q <= '0; pcnt_q <= '0; tick_q <= '0; mark_q <= '0;
      last_q <= '0; err_q <= '0;
      baddr_q <= 1'b0; rto_q <= 8'd128; plim_q <= 9'd256;
    end else begin
      if (step_i) begin
        phase_q <= phase_d; slot_q <= slot_d; app_q <= app_d; busy_q <= busy_d;
        flush_q <= flush_d; swap_q <= swap_d; blen_q <= blen_d; sblen_q <= sblen_d;
        bcnt_q <= bcnt_d; arg_q <= arg_d; pcnt_q <= pcnt_d; tick_q <= tick_d;
        mark_q <= mark_d; last_q <= last_d; err_q <= err_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdspi_pkg::CfgBlockAddr:   baddr_q <= cfg_data_i[0];
          sdspi_pkg::CfgReadTimeout: rto_q   <= cfg_data_i[7:0];
          sdspi_pkg::CfgPollLimit:   plim_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/sd_spi_command_engine.sv @@
`timescale 1ns / 1ps
// Result: registered; it appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the next-step logic sits between the
// input handshake and the result register.
// Reset: asynchronous, active low; phase idle, block length 512,
// registers 0 / 128 / 256.
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// SD card SPI-mode host command sequencer, at most one byte exchange per transaction.
// ----------------------------------------------------------------------------
`include "sd_spi_command_engine_assert.svh"
module sd_spi_command_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  cmd_slot_i,
  input  logic [31:0] cmd_argument_i,
  input  logic [7:0]  miso_byte_i,
  input  logic [7:0]  wdata_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  mosi_byte_o,
  output logic        exchange_valid_o,
  output logic        cs_active_o,
  output logic        data_request_o,
  output logic [7:0]  rdata_byte_o,
  output logic        rdata_valid_o,
  output logic        done_res_o,
  output logic [7:0]  response_byte_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  logic               accept;
  logic               ovalid_q;
  sdspi_pkg::result_t res, res_q;

  assign in_stall_o = ovalid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  sdspi_core u_core (
    .clk_i, .rst_ni, .step_i(accept), .kind_i, .cmd_slot_i, .cmd_argument_i,
    .miso_byte_i, .wdata_byte_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ovalid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign mosi_byte_o      = res_q.mosi_byte;
  assign exchange_valid_o = res_q.exchange_valid;
  assign cs_active_o      = res_q.cs_active;
  assign data_request_o   = res_q.data_request;
  assign rdata_byte_o     = res_q.rdata_byte;
  assign rdata_valid_o    = res_q.rdata_valid;
  assign done_res_o       = res_q.done_res;
  assign response_byte_o  = res_q.response_byte;
  assign status_o         = res_q.status;

  `SSCE_ASSERT(a_stall_only_full, in_stall_o |-> out_valid_o, "stall without result")
  `SSCE_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `SSCE_ASSERT(a_load, accept |=> out_valid_o, "accepted item lost")
  `SSCE_NEVER(a_dreq_xchg, out_valid_o && data_request_o && !exchange_valid_o, "stray request")
  `SSCE_NEVER(a_done_xchg, out_valid_o && done_res_o && exchange_valid_o, "done with exchange")

endmodule
